### rtl/multi_client_watchdog_macros.svh
// assertion helpers for the watchdog
`ifndef MULTI_CLIENT_WATCHDOG_MACROS_SVH
`define MULTI_CLIENT_WATCHDOG_MACROS_SVH

// condition implies consequence in the same cycle
`define MCW_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define MCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/mcw_pkg.sv
`default_nettype none
package mcw_pkg;

  localparam int MAX_CLIENTS_DEF = 8;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam logic [2:0] FN_REGISTER = 3'd0;
  localparam logic [2:0] FN_START    = 3'd1;
  localparam logic [2:0] FN_STOP     = 3'd2;
  localparam logic [2:0] FN_KICK     = 3'd3;
  localparam logic [2:0] FN_TICK     = 3'd4;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_RUNNING    = 3'd1;
  localparam logic [2:0] ST_DUPLICATE  = 3'd2;
  localparam logic [2:0] ST_NO_CLIENTS = 3'd3;
  localparam logic [2:0] ST_STOPPED    = 3'd4;
  localparam logic [2:0] ST_UNREG      = 3'd5;

  typedef struct packed {
    logic [2:0]  func;
    logic [2:0]  client;
    logic [15:0] timeout_ticks;
  } cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic       expired_valid;
    logic [2:0] expired_client;
    logic       last;
  } rsp_t;

  typedef struct packed {
    logic wr;
    logic reload;
    logic tick;
    logic shift;
  } cell_ctl_t;

endpackage
`default_nettype wire

### rtl/mcw_cell.sv
`default_nettype none
module mcw_cell
  import mcw_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire cell_ctl_t              ctl,
  input  wire logic [COUNT_WIDTH-1:0] tmo_in,
  input  wire logic                   flag_in,
  output logic                        registered,
  output logic                        flag,
  output logic                        expire
);

  logic [COUNT_WIDTH-1:0] tmo;
  logic [COUNT_WIDTH-1:0] rem;
  logic [COUNT_WIDTH-1:0] dec;

  assign dec    = (rem != '0) ? rem - COUNT_WIDTH'(1) : rem;
  assign expire = registered && (dec == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      registered <= 1'b0;
      flag       <= 1'b0;
    end else begin
      if (ctl.wr) begin
        registered <= 1'b1;
      end
      priority if (ctl.shift) begin
        flag <= flag_in;
      end else if (ctl.tick) begin
        flag <= expire;
      end else begin
        flag <= flag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      tmo <= tmo_in;
    end
    priority if (ctl.reload && registered) begin
      rem <= tmo;
    end else if (ctl.tick && registered) begin
      rem <= expire ? tmo : dec;
    end else begin
      rem <= rem;
    end
  end

endmodule
`default_nettype wire

### rtl/multi_client_watchdog.sv
// multi-client watchdog
// cmd channel (cmd_valid / cmd_stall / cmd) carries register, start, stop,
// kick and tick items; rsp channel (rsp_valid / rsp_stall / rsp) returns
// results. every item but an unused func code gives one result with last
// set, except a tick while running that finds expired clients: it gives
// one result per expired client, lowest slot first, last set on the last.
// one row of cells, one per client slot, holds timeout, counter and an
// expiry flag; after such a tick the flags shift toward slot 0 one cell per
// cycle, held while a result for slot 0 waits on a stalled rsp channel.
// an item is taken into a holding register and executed once no walk is
// on and the result register is free; unless it starts a walk, its result
// shows at the end of that cycle. a new item waits in the holding register
// until a walk is over. a stalled result holds the holding register; one
// more item is accepted behind it. reset clears the running state, the
// registered clients, the holding register's valid and the result valid.
`default_nettype none
`include "multi_client_watchdog_macros.svh"
module multi_client_watchdog
  import mcw_pkg::*;
#(
  parameter int MAX_CLIENTS = MAX_CLIENTS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_stall,
  input  wire cmd_t cmd,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  typedef enum logic {IDLE, SCAN} state_t;

  state_t                 state;
  cmd_t                   held;
  logic                   held_valid;
  logic                   running;
  logic [IDX_W-1:0]       idx;

  logic                   out_free;
  logic                   exec;
  logic                   shift_en;
  logic                   rsp_load;
  logic                   any_exp;
  logic                   slot_ok;
  logic                   slot_reg;
  logic                   scan_last;
  logic [2:0]             st;
  logic [15:0]            tmo_fix;
  logic [COUNT_WIDTH-1:0] tmo_val;
  logic [MAX_CLIENTS-1:0] sel;
  logic [MAX_CLIENTS-1:0] reg_mask;
  logic [MAX_CLIENTS-1:0] flags;
  logic [MAX_CLIENTS-1:0] exp_now;
  cell_ctl_t              ctl [MAX_CLIENTS];

  assign cmd_stall = held_valid;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign exec      = (state == IDLE) && held_valid && out_free;
  assign shift_en  = (state == SCAN) && (!flags[0] || out_free);
  assign rsp_load  = (exec && (held.func <= FN_TICK) &&
                      !((held.func == FN_TICK) && running && any_exp)) ||
                     (shift_en && flags[0]);
  assign any_exp   = |exp_now;
  assign slot_ok   = 32'(held.client) < MAX_CLIENTS;
  assign slot_reg  = |(sel & reg_mask);
  assign scan_last = ~|(flags >> 1);
  assign tmo_fix   = (held.timeout_ticks == 16'd0) ? 16'd1 : held.timeout_ticks;

  if (COUNT_WIDTH >= 16) begin : g_wide
    assign tmo_val = COUNT_WIDTH'(tmo_fix);
  end else begin : g_narrow
    assign tmo_val = (tmo_fix > 16'(CMAX)) ? CMAX : tmo_fix[COUNT_WIDTH-1:0];
  end

  for (genvar i = 0; i < MAX_CLIENTS; i++) begin : g_cell
    logic flag_next;

    assign sel[i] = (held.client == 3'(i));
    assign flag_next = (i == MAX_CLIENTS - 1) ? 1'b0 : flags[(i + 1) % MAX_CLIENTS];

    assign ctl[i].wr     = exec && (held.func == FN_REGISTER) && !running && sel[i] &&
                           !reg_mask[i];
    assign ctl[i].reload = exec && (((held.func == FN_START) && !running && (|reg_mask)) ||
                           ((held.func == FN_KICK) && running && sel[i]));
    assign ctl[i].tick   = exec && (held.func == FN_TICK) && running;
    assign ctl[i].shift  = shift_en;

    mcw_cell #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl[i]),
      .tmo_in    (tmo_val),
      .flag_in   (flag_next),
      .registered(reg_mask[i]),
      .flag      (flags[i]),
      .expire    (exp_now[i])
    );
  end

  always_comb begin
    st = ST_OK;
    unique case (held.func)
      FN_REGISTER: begin
        if (running) begin
          st = ST_RUNNING;
        end else if (!slot_ok) begin
          st = ST_UNREG;
        end else if (slot_reg) begin
          st = ST_DUPLICATE;
        end
      end
      FN_START: begin
        if (running) begin
          st = ST_RUNNING;
        end else if (reg_mask == '0) begin
          st = ST_NO_CLIENTS;
        end
      end
      FN_STOP: begin
        if (!running) begin
          st = ST_STOPPED;
        end
      end
      FN_KICK: begin
        if (!running) begin
          st = ST_STOPPED;
        end else if (!slot_reg) begin
          st = ST_UNREG;
        end
      end
      default: st = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      held_valid <= 1'b0;
      rsp_valid  <= 1'b0;
      running    <= 1'b0;
      idx        <= '0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        held       <= cmd;
        held_valid <= 1'b1;
      end else if (exec) begin
        held_valid <= 1'b0;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (exec) begin
            if ((held.func == FN_START) && (st == ST_OK)) begin
              running <= 1'b1;
            end
            if ((held.func == FN_STOP) && (st == ST_OK)) begin
              running <= 1'b0;
            end
            if ((held.func == FN_TICK) && running && any_exp) begin
              state <= SCAN;
              idx   <= '0;
            end else if (held.func <= FN_TICK) begin
              rsp.status         <= st;
              rsp.expired_valid  <= 1'b0;
              rsp.expired_client <= 3'd0;
              rsp.last           <= 1'b1;
            end
          end
        end
        SCAN: begin
          if (shift_en) begin
            idx <= idx + IDX_W'(1);
            if (flags[0]) begin
              rsp.status         <= ST_OK;
              rsp.expired_valid  <= 1'b1;
              rsp.expired_client <= 3'(idx);
              rsp.last           <= scan_last;
              if (scan_last) begin
                state <= IDLE;
              end
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  `MCW_ASSERT_IMPL(a_scan_has_flag, clk, rst, state == SCAN, |flags, "scan with no expiry flag")
  `MCW_ASSERT_NEXT(a_scan_mask_stable, clk, rst, state == SCAN, $stable(reg_mask), "mask changed during scan")
  `MCW_ASSERT_IMPL(a_running_has_client, clk, rst, running, |reg_mask, "running with no clients")
  `MCW_ASSERT_IMPL(a_exec_only_idle, clk, rst, |(ctl[0]), (state == IDLE) || ctl[0].shift, "cell control outside idle")

endmodule
`default_nettype wire
